### src/srp_pkg.sv
// Shared types and constants for the slope ramp planner.
package srp_pkg;

  // Step registers are unsigned Q15.16 values of 31 bits.
  localparam int StepW = 31;
  localparam logic [StepW-1:0] StepReset = 31'd65536;

  // Configuration write port.
  localparam int CfgIndexW = 1;
  localparam int CfgDataW = 32;

  typedef enum logic [CfgIndexW-1:0] {
    CfgIncreaseStep = 1'b0,
    CfgDecreaseStep = 1'b1
  } cfg_reg_e;

endpackage

### src/srp_step.sv
// Combinational step logic: moves the plan toward the target by one limited step.
module srp_step #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic signed [VALUE_WIDTH-1:0] plan_i,
  input  logic signed [VALUE_WIDTH-1:0] target_i,
  input  logic signed [VALUE_WIDTH-1:0] feedback_i,
  input  logic [srp_pkg::StepW-1:0]     increase_step_i,
  input  logic [srp_pkg::StepW-1:0]     decrease_step_i,
  output logic signed [VALUE_WIDTH-1:0] result_o
);
  import srp_pkg::*;

  // Wide enough for a saturating add of a full step to any value.
  localparam int SumW = ((VALUE_WIDTH > StepW) ? VALUE_WIDTH : StepW) + 2;

  logic                          going_up;
  logic                          in_between;
  logic                          rising;
  logic signed [VALUE_WIDTH-1:0] base;
  logic signed [VALUE_WIDTH:0]   gap_s;
  logic [VALUE_WIDTH-1:0]        gap;
  logic [StepW-1:0]              step;
  logic [SumW-1:0]               gap_ext;
  logic [SumW-1:0]               step_ext;
  logic signed [SumW-1:0]        base_ext;
  logic signed [SumW-1:0]        step_s;
  logic signed [SumW-1:0]        sum_up;
  logic signed [SumW-1:0]        sum_dn;
  logic signed [SumW-1:0]        max_ext;
  logic signed [SumW-1:0]        min_ext;
  logic signed [VALUE_WIDTH-1:0] stepped;

  assign going_up = target_i > plan_i;

  // Feedback lying between plan and target (inclusive) becomes the new base.
  assign in_between = ((target_i >= feedback_i) && (feedback_i >= plan_i)) ||
                      ((target_i <= feedback_i) && (feedback_i <= plan_i));
  assign base = in_between ? feedback_i : plan_i;

  // Distance from plan to target is never negative and fits VALUE_WIDTH bits.
  always_comb begin
    if (going_up) begin
      gap_s = {target_i[VALUE_WIDTH-1], target_i} - {plan_i[VALUE_WIDTH-1], plan_i};
    end else begin
      gap_s = {plan_i[VALUE_WIDTH-1], plan_i} - {target_i[VALUE_WIDTH-1], target_i};
    end
  end
  assign gap = gap_s[VALUE_WIDTH-1:0];

  // A zero plan counts as rising in both directions.
  always_comb begin
    if (plan_i[VALUE_WIDTH-1]) begin
      rising = target_i < plan_i;
    end else if (plan_i != '0) begin
      rising = going_up;
    end else begin
      rising = 1'b1;
    end
  end
  assign step = rising ? increase_step_i : decrease_step_i;

  assign gap_ext  = {{(SumW-VALUE_WIDTH){1'b0}}, gap};
  assign step_ext = {{(SumW-StepW){1'b0}}, step};
  assign base_ext = {{(SumW-VALUE_WIDTH){base[VALUE_WIDTH-1]}}, base};
  assign step_s   = step_ext;
  assign max_ext  = {{(SumW-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
  assign min_ext  = {{(SumW-VALUE_WIDTH+1){1'b1}}, {(VALUE_WIDTH-1){1'b0}}};
  assign sum_up   = base_ext + step_s;
  assign sum_dn   = base_ext - step_s;

  always_comb begin
    if (going_up) begin
      stepped = (sum_up > max_ext) ? max_ext[VALUE_WIDTH-1:0] : sum_up[VALUE_WIDTH-1:0];
    end else begin
      stepped = (sum_dn < min_ext) ? min_ext[VALUE_WIDTH-1:0] : sum_dn[VALUE_WIDTH-1:0];
    end
  end

  always_comb begin
    if (target_i == plan_i) begin
      result_o = base;
    end else if (gap_ext > step_ext) begin
      result_o = stepped;
    end else begin
      result_o = target_i;
    end
  end

endmodule

### src/slope_ramp_planner_unit.sv
// A result passes through the input stage and then the result register; one item per cycle
// unless the result stalls, and the plan loop closes through the result register.
// The input stage, when empty, takes a new item while a finished result waits downstream.
// Reset clears the plan to zero and both step registers to 1.0 (Q15.16).
// No clearing pass is needed after reset.
module slope_ramp_planner_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [VALUE_WIDTH-1:0]   target_i,
  input  logic signed [VALUE_WIDTH-1:0]   feedback_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [VALUE_WIDTH-1:0]   ramp_output_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [srp_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [srp_pkg::CfgDataW-1:0]    cfg_data_i
);
  import srp_pkg::*;

  logic                          s1_valid_q;
  logic signed [VALUE_WIDTH-1:0] target_q;
  logic signed [VALUE_WIDTH-1:0] feedback_q;
  logic                          out_valid_q;
  logic signed [VALUE_WIDTH-1:0] ramp_q;
  logic signed [VALUE_WIDTH-1:0] ramp_d;
  logic [StepW-1:0]              inc_step_q;
  logic [StepW-1:0]              dec_step_q;
  logic                          advance;
  logic                          cfg_write;

  // The result register doubles as the stored plan.
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign cfg_ready_o = 1'b1;
  assign cfg_write  = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      target_q   <= target_i;
      feedback_q <= feedback_i;
    end
  end

  srp_step #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_step (
    .plan_i         (ramp_q),
    .target_i       (target_q),
    .feedback_i     (feedback_q),
    .increase_step_i(inc_step_q),
    .decrease_step_i(dec_step_q),
    .result_o       (ramp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      ramp_q      <= '0;
    end else begin
      if (advance) begin
        ramp_q <= ramp_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ramp_output_o = ramp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_step_q <= StepReset;
      dec_step_q <= StepReset;
    end else if (cfg_write) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgIncreaseStep: inc_step_q <= cfg_data_i[StepW-1:0];
        CfgDecreaseStep: dec_step_q <= cfg_data_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  // The input stage only refuses an item when it is full and the result is stalled.
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input refused without a downstream stall");

  a_advance_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced item did not reach the result register");

  a_held_item_keeps_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> (s1_valid_q && $stable(target_q) && $stable(feedback_q)))
    else $error("held item lost or changed in the input stage");

  a_plan_holds_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(ramp_q))
    else $error("plan changed without an item");

  a_cfg_increase_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_write && (cfg_reg_e'(cfg_index_i) == CfgIncreaseStep))
      |=> (inc_step_q == $past(cfg_data_i[StepW-1:0])))
    else $error("increase step write not taken");

endmodule

### bench/slope_ramp_planner_unit_tb.sv
// Self-checking testbench for the slope ramp planner: directed ticks, then random ticks.
`timescale 1ns / 1ps

module slope_ramp_planner_unit_tb;
  import srp_pkg::*;

  localparam int ValW = 32;
  localparam longint ValMax = 64'sd2147483647;
  localparam longint ValMin = -64'sd2147483648;
  localparam int CycleLimit = 200000;
  localparam int RandPhases = 8;
  localparam int ItemsPerPhase = 129;
  localparam int DirRows = 16;

  typedef struct packed {
    logic signed [ValW-1:0] target;
    logic signed [ValW-1:0] feedback;
    logic                   known;
    logic signed [ValW-1:0] ramp;
  } ramp_row_t;

  // Rows with known set carry the result read straight off the rules; the
  // rest are checked against the predictor. Steps are at their reset value.
  localparam ramp_row_t DirTable [DirRows] = '{
    '{32'sh0000_0000, 32'sh0000_0000, 1'b1, 32'sh0000_0000},
    '{32'sh0000_8000, 32'sh0000_0000, 1'b1, 32'sh0000_8000},
    '{32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, 32'sh0001_8000},
    '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 32'sh7FFF_FFFF},
    '{32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 32'sh7FFE_FFFF},
    '{32'sh8000_0000, 32'sh8000_0000, 1'b1, 32'sh8000_0000},
    '{32'sh8000_0000, 32'sh1234_5678, 1'b1, 32'sh8000_0000},
    '{32'sh7FFF_FFFF, 32'sh0000_0000, 1'b1, 32'sh0001_0000},
    '{32'sh0001_8000, 32'sh0001_4000, 1'b1, 32'sh0001_8000},
    '{32'sh0001_8000, 32'sh0001_8000, 1'b1, 32'sh0001_8000},
    '{32'shFFFB_0000, 32'sh0000_8000, 1'b0, 32'sh0000_0000},
    '{32'sh0000_0000, 32'sh0000_0000, 1'b0, 32'sh0000_0000},
    '{32'shFFFD_0000, 32'sh0004_0000, 1'b0, 32'sh0000_0000},
    '{32'sh5555_5555, 32'shAAAA_AAAA, 1'b0, 32'sh0000_0000},
    '{32'shAAAA_AAAA, 32'sh5555_5555, 1'b0, 32'sh0000_0000},
    '{32'sh0000_0001, 32'shFFFF_FFFF, 1'b0, 32'sh0000_0000}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic signed [ValW-1:0] target = '0;
  logic signed [ValW-1:0] feedback = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic signed [ValW-1:0] ramp_output;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  cfg_reg_e               cfg_index = CfgIncreaseStep;
  logic [CfgDataW-1:0]    cfg_data = '0;

  // Predictor state: the plan and both step registers.
  logic signed [ValW-1:0] plan_q = '0;
  logic [StepW-1:0]       inc_step_q = StepReset;
  logic [StepW-1:0]       dec_step_q = StepReset;

  logic signed [ValW-1:0] ramp_expect_q [$];
  int send_idle_pct = 0;
  int rcv_stall_pct = 0;
  int ticks_sent = 0;
  int ramps_checked = 0;
  int mismatches = 0;
  int cfg_writes = 0;

  slope_ramp_planner_unit #(
    .VALUE_WIDTH(ValW)
  ) u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .target_i     (target),
    .feedback_i   (feedback),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .ramp_output_o(ramp_output),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic longint clamp_val(input longint v);
    if (v > ValMax) return ValMax;
    if (v < ValMin) return ValMin;
    return v;
  endfunction

  // Next plan for one tick, given the current plan and step registers.
  function automatic logic signed [ValW-1:0] next_ramp(input logic signed [ValW-1:0] tgt_v,
                                                       input logic signed [ValW-1:0] fb_v);
    longint tgt, fb, plan, res, diff, stp;
    bit rising;
    tgt = tgt_v;
    fb = fb_v;
    plan = plan_q;
    res = plan;
    if ((tgt >= fb && fb >= plan) || (tgt <= fb && fb <= plan)) res = fb;
    if (tgt != plan) begin
      diff = (plan >= tgt) ? plan - tgt : tgt - plan;
      if (plan > 0) rising = tgt > plan;
      else if (plan < 0) rising = tgt < plan;
      else rising = 1'b1;
      stp = rising ? longint'(inc_step_q) : longint'(dec_step_q);
      if (diff > stp) res = clamp_val((tgt > plan) ? res + stp : res - stp);
      else res = tgt;
    end
    return res[ValW-1:0];
  endfunction

  // Random tick aimed near the current plan so that snapping, the step
  // boundary and the feedback jump come up often.
  task automatic pick_tick(output logic signed [ValW-1:0] tgt_o,
                           output logic signed [ValW-1:0] fb_o);
    longint plan, t, f, span, lo, hi, dir;
    int unsigned sel;
    plan = plan_q;
    span = $urandom_range(0, 1) ? longint'(inc_step_q) : longint'(dec_step_q);
    dir = $urandom_range(0, 1) ? 1 : -1;
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      t = longint'($signed($urandom));
    end else if (sel < 16) begin
      case ($urandom_range(0, 2))
        0: t = ValMin;
        1: t = ValMax;
        default: t = 0;
      endcase
    end else if (sel < 22) begin
      t = plan;
    end else if (sel < 42) begin
      t = plan + dir * (span - 1 + longint'($urandom_range(0, 2)));
    end else begin
      t = plan + dir * (longint'($urandom) % (2 * span + 2));
    end
    t = clamp_val(t);
    lo = (plan < t) ? plan : t;
    hi = (plan < t) ? t : plan;
    sel = $urandom_range(0, 99);
    if (sel < 35) f = lo + longint'($urandom) % (hi - lo + 1);
    else if (sel < 45) f = plan;
    else if (sel < 55) f = t;
    else if (sel < 62) f = clamp_val(plan + dir);
    else f = longint'($signed($urandom));
    tgt_o = t[ValW-1:0];
    fb_o = f[ValW-1:0];
  endtask

  // Present one tick, wait for it to be taken, then record its expected result.
  task automatic send_tick(input logic signed [ValW-1:0] tgt, input logic signed [ValW-1:0] fb,
                           input logic known, input logic signed [ValW-1:0] ramp_known);
    logic signed [ValW-1:0] ramp_pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    target <= tgt;
    feedback <= fb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ramp_pred = next_ramp(tgt, fb);
    plan_q = ramp_pred;
    ramp_expect_q.push_back(known ? ramp_known : ramp_pred);
    ticks_sent++;
  endtask

  task automatic write_step(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CfgIncreaseStep) inc_step_q = data[StepW-1:0];
    else dec_step_q = data[StepW-1:0];
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // The sender holds off here until every outstanding result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (ramp_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(negedge clk) begin
    out_ready <= (rcv_stall_pct == 0) ? 1'b1 : ($urandom_range(0, 99) >= rcv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (ramp_expect_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected ramp_output, expected none, actual %h", $time, ramp_output);
      end else begin
        ramps_checked++;
        if (ramp_output !== ramp_expect_q[0]) begin
          mismatches++;
          $display("%0t: ramp_output mismatch, expected %h, actual %h",
                   $time, ramp_expect_q[0], ramp_output);
        end
        void'(ramp_expect_q.pop_front());
      end
    end
  end

  initial begin
    int cyc;
    for (cyc = 0; cyc < CycleLimit; cyc++) @(posedge clk);
    $display("%0t: run timed out with %0d results outstanding", $time, ramp_expect_q.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic signed [ValW-1:0] tgt, fb;
    logic [CfgDataW-1:0] inc_data, dec_data;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DirRows; r++) begin
      send_tick(DirTable[r].target, DirTable[r].feedback, DirTable[r].known, DirTable[r].ramp);
    end
    drain_results();

    for (int p = 0; p < RandPhases; p++) begin
      // Step settings include both extremes; bit 31 of the data must be dropped.
      case (p)
        0: begin inc_data = 32'h0000_8000; dec_data = 32'h0002_0000; end
        1: begin inc_data = 32'h0000_0000; dec_data = 32'h0000_0000; end
        2: begin inc_data = 32'hFFFF_FFFF; dec_data = 32'h7FFF_FFFF; end
        3: begin inc_data = 32'h0000_0000; dec_data = 32'hFFFF_FFFF; end
        4: begin inc_data = 32'h7FFF_FFFF; dec_data = 32'h8000_0000; end
        5: begin inc_data = $urandom_range(1, 32'h4_0000); dec_data = $urandom_range(1, 32'h4_0000); end
        default: begin inc_data = $urandom; dec_data = $urandom; end
      endcase
      if (p[0]) begin
        write_step(CfgDecreaseStep, dec_data);
        write_step(CfgIncreaseStep, inc_data);
      end else begin
        write_step(CfgIncreaseStep, inc_data);
        write_step(CfgDecreaseStep, dec_data);
      end
      case (p % 4)
        0: begin send_idle_pct = 0; rcv_stall_pct = 0; end
        1: begin send_idle_pct = 59; rcv_stall_pct = 0; end
        2: begin send_idle_pct = 0; rcv_stall_pct = 59; end
        default: begin send_idle_pct = 12; rcv_stall_pct = 12; end
      endcase
      for (int i = 0; i < ItemsPerPhase; i++) begin
        pick_tick(tgt, fb);
        send_tick(tgt, fb, 1'b0, '0);
      end
      drain_results();
      send_idle_pct = 0;
      rcv_stall_pct = 0;
    end

    $display("Sent %0d ticks (%0d directed) and checked %0d ramp outputs.",
             ticks_sent, DirRows, ramps_checked);
    $display("Made %0d step register writes over %0d settings and four handshake patterns.",
             cfg_writes, RandPhases);
    if (mismatches == 0 && ramp_expect_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, ramp_expect_q.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
src/srp_pkg.sv
src/srp_step.sv
src/slope_ramp_planner_unit.sv
bench/slope_ramp_planner_unit_tb.sv
